// File: rtl/adpf_pkg.sv
// ----------------------------------------------------------------------------
// adpf_pkg
// shared constants, codes and controller/datapath types of the audio fifo
// ----------------------------------------------------------------------------
package adpf_pkg;

  // ring geometry
  localparam int RING_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int PTR_W      = ADDR_W + 1;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 32;
  localparam int LEN_W    = 6;
  localparam int FILL_W   = 11;
  localparam int CFG_W    = 1;
  localparam int CFG_IDX_W = 1;

  // fill thresholds and packet lengths
  localparam int PRIME_LEVEL = 96;
  localparam int HIGH_LEVEL  = 144;
  localparam int LOW_LEVEL   = 96;
  localparam int LEN_LONG    = 49;
  localparam int LEN_SHORT   = 47;
  localparam int LEN_NORMAL  = 48;

  // operation codes
  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_MODE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic push;   // store one sample item
    logic start;  // latch packet parameters
    logic slot;   // handle one packet slot, read ring
    logic load;   // fill the output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;   // output register empty or emptied this cycle
    logic slot_last;  // current slot is the last of the packet
  } dp_status_t;

endpackage

// File: rtl/adpf_in_if.sv
// ----------------------------------------------------------------------------
// adpf_in_if
// input channel: push and packet request items
// ----------------------------------------------------------------------------
interface adpf_in_if import adpf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic signed [SAMPLE_W-1:0] first_sample;
  logic signed [SAMPLE_W-1:0] second_sample;

  modport source (output valid, operation, first_sample, second_sample, input ready);
  modport sink   (input valid, operation, first_sample, second_sample, output ready);
endinterface

// File: rtl/adpf_out_if.sv
// ----------------------------------------------------------------------------
// adpf_out_if
// output channel: one packet sample per beat with status snapshot
// ----------------------------------------------------------------------------
interface adpf_out_if import adpf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       last;
  logic [LEN_W-1:0]           packet_length;
  logic [FILL_W-1:0]          fill_level;
  logic [SAMPLE_W-1:0]        peak_magnitude;
  logic [COUNT_W-1:0]         overrun_count;
  logic [COUNT_W-1:0]         underrun_count;
  logic [COUNT_W-1:0]         received_count;
  logic [COUNT_W-1:0]         nonzero_count;

  modport source (
    output valid, sample_out, last, packet_length, fill_level, peak_magnitude,
           overrun_count, underrun_count, received_count, nonzero_count,
    input  ready
  );
  modport sink (
    input  valid, sample_out, last, packet_length, fill_level, peak_magnitude,
           overrun_count, underrun_count, received_count, nonzero_count,
    output ready
  );
endinterface

// File: rtl/adpf_ctrl.sv
// ----------------------------------------------------------------------------
// adpf_ctrl
// sequencer: accepts items, steps through packet slots
// ----------------------------------------------------------------------------
module adpf_ctrl import adpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_operation,
  output logic       item_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid && item_operation == OP_PACKET) state_next = ST_SLOT;
      end
      ST_SLOT: begin
        if (status.out_free) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = status.slot_last ? ST_IDLE : ST_SLOT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.push   = item_valid && item_operation == OP_PUSH;
        cmd.start  = item_valid && item_operation == OP_PACKET;
      end
      ST_SLOT: begin
        cmd.slot = status.out_free;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/adpf_dp.sv
// ----------------------------------------------------------------------------
// adpf_dp
// datapath: config, sample ring, statistics counters, output register
// ----------------------------------------------------------------------------
module adpf_dp import adpf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic signed [SAMPLE_W-1:0] first_sample,
  input  logic signed [SAMPLE_W-1:0] second_sample,
  input  dp_cmd_t                    cmd,
  output dp_status_t                 status,
  adpf_out_if.source                 result
);

  logic enabled;
  logic pair_mode;

  logic [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic [SAMPLE_W-1:0] rd_data;
  logic                took;

  logic [PTR_W-1:0]    write_pointer;
  logic [PTR_W-1:0]    read_pointer;
  logic                primed;
  logic [SAMPLE_W-1:0] peak_level;
  logic [COUNT_W-1:0]  overruns;
  logic [COUNT_W-1:0]  underruns;
  logic [COUNT_W-1:0]  received;
  logic [COUNT_W-1:0]  nonzero;

  // per packet
  logic [PTR_W-1:0]    pkt_fill;
  logic                live;
  logic [LEN_W-1:0]    count;
  logic [LEN_W-1:0]    slot_idx;

  logic                out_valid;

  logic [PTR_W-1:0]          fill;
  logic signed [SAMPLE_W:0]  sum;
  logic signed [SAMPLE_W:0]  sum_adj;
  logic [SAMPLE_W-1:0]       smp;
  logic [SAMPLE_W-1:0]       mag;
  logic                      ring_full;
  logic                      prime_now;
  logic                      live_now;
  logic [LEN_W-1:0]          count_now;
  logic                      rd_en;

  // fill from pointers that count modulo twice the depth
  assign fill      = write_pointer - read_pointer;
  assign ring_full = fill == PTR_W'(RING_DEPTH);

  // pair average, truncated toward zero
  assign sum     = {first_sample[SAMPLE_W-1], first_sample}
                 + {second_sample[SAMPLE_W-1], second_sample};
  assign sum_adj = sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W]};
  assign smp     = pair_mode ? sum_adj[SAMPLE_W:1] : first_sample;
  assign mag     = smp[SAMPLE_W-1] ? (~smp + 1'b1) : smp;

  assign prime_now = primed || fill >= PTR_W'(PRIME_LEVEL);
  assign live_now  = enabled && prime_now;

  always_comb begin
    count_now = LEN_W'(LEN_NORMAL);
    if (live_now) begin
      priority if (fill > PTR_W'(HIGH_LEVEL)) count_now = LEN_W'(LEN_LONG);
      else if (fill < PTR_W'(LOW_LEVEL))      count_now = LEN_W'(LEN_SHORT);
      else                                    count_now = LEN_W'(LEN_NORMAL);
    end
  end

  assign rd_en = cmd.slot && live && read_pointer != write_pointer;

  assign status.out_free  = !out_valid || result.ready;
  assign status.slot_last = slot_idx == count - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      pair_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLED:   enabled   <= cfg_data[0];
        CFG_PAIR_MODE: pair_mode <= cfg_data[0];
        default:       enabled   <= enabled;
      endcase
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (cmd.push && enabled && !ring_full) begin
      ring[write_pointer[ADDR_W-1:0]] <= smp;
    end
    if (rd_en) begin
      rd_data <= ring[read_pointer[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      primed        <= 1'b0;
      peak_level    <= '0;
      overruns      <= '0;
      underruns     <= '0;
      received      <= '0;
      nonzero       <= '0;
      took          <= 1'b0;
    end else begin
      if (cmd.push && enabled) begin
        if (mag > peak_level) peak_level <= mag;
        if (smp != '0) nonzero <= nonzero + 1'b1;
        if (ring_full) overruns <= overruns + 1'b1;
        else           write_pointer <= write_pointer + 1'b1;
        received <= received + 1'b1;
      end
      if (cmd.start) primed <= prime_now;
      if (cmd.slot) begin
        took <= rd_en;
        if (rd_en)     read_pointer <= read_pointer + 1'b1;
        else if (live) underruns <= underruns + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pkt_fill <= fill;
      live     <= live_now;
      count    <= count_now;
      slot_idx <= '0;
    end else if (cmd.load) begin
      slot_idx <= slot_idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result.sample_out     <= took ? rd_data : '0;
      result.last           <= status.slot_last;
      result.packet_length  <= count;
      result.fill_level     <= FILL_W'(pkt_fill);
      result.peak_magnitude <= peak_level;
      result.overrun_count  <= overruns;
      result.underrun_count <= underruns;
      result.received_count <= received;
      result.nonzero_count  <= nonzero;
    end
  end

  assign result.valid = out_valid;

endmodule

// File: rtl/audio_decimating_packet_fifo_top.sv
// ----------------------------------------------------------------------------
// audio_decimating_packet_fifo_top
// audio capture fifo with pair averaging and adaptive packet length
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake     | beat payload
//   ---------+-----+---------------+-----------------------------------------
//   item     | in  | valid/ready   | operation, first_sample, second_sample
//   result   | out | valid/ready   | sample_out, last, packet_length, fill,
//            |     |               | peak and the four statistics counters
//   cfg      | in  | cfg_we only   | cfg_index, cfg_data
//
// a push item is taken in the idle step; a packet request is accepted there,
// then each packet sample takes a slot step (ring read) and a load step
// (output register load); the slot step waits for a free output register
// reset is synchronous and clears pointers, counters, config and the sequencer
// the ring itself has no reset; only entries written before are ever read
// a stalled result holds the sequencer in the slot step; pushes are taken
// while the final beat of a packet still waits in the output register
//
module audio_decimating_packet_fifo_top import adpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  adpf_in_if.sink              item,
  adpf_out_if.source           result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: item acceptance and slot stepping
  adpf_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item.valid),
    .item_operation (item.operation),
    .item_ready     (item.ready),
    .status         (status),
    .cmd            (cmd)
  );

  // ring, counters and the output register
  adpf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .first_sample  (item.first_sample),
    .second_sample (item.second_sample),
    .cmd           (cmd),
    .status        (status),
    .result        (result)
  );

endmodule
